[rtl/core/nmf_pkg.sv]
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared constants and types of the four-neighbour mean filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmf_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int SUM_BITS           = SAMPLE_BITS + 2;
    localparam int MAG_BITS           = SUM_BITS;
    localparam int CNT_BITS           = 3;
    localparam int ROW_CFG_BITS       = 11;
    localparam int COL_BITS           = 16;
    localparam int CFG_INDEX_BITS     = 4;
    localparam int CFG_DATA_BITS      = 16;
    localparam int DEFAULT_MAX_ROWS   = 1024;
    localparam int RESET_ROW_COUNT    = 256;
    localparam int RESET_COLUMN_COUNT = 256;
    localparam int QUEUE_DEPTH        = 4;

    // divide by three: floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT for x < 2^MAG_BITS
    localparam int DIV3_SHIFT = MAG_BITS + 1;
    localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP =
        DIV3_SHIFT'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
    localparam int PROD_BITS = MAG_BITS + DIV3_SHIFT;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_COUNT    = 0,
        CFG_COLUMN_COUNT = 1
    } t_cfg_index;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   missing;
    } t_cell;

    // one row of the column store: last column and the one before it
    typedef struct packed {
        t_cell prev;
        t_cell old;
    } t_line_entry;

    typedef struct packed {
        logic has_first;     // result for the previous column
        logic first_border;
        logic has_second;    // last column's own border result
        logic last;
    } t_class;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0] cnt;
        t_class              cls;
    } t_job;

endpackage

[rtl/core/nmf_if.sv]
// ----------------------------------------------------------------------------
// nmf_if
// Valid/ready channels of the four-neighbour mean filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nmf_sample_if;
    import nmf_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          sample_missing;

    modport source (output valid, sample_value, sample_missing, input ready);
    modport sink   (input valid, sample_value, sample_missing, output ready);
endinterface

interface nmf_result_if;
    import nmf_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic                          no_valid_neighbour;
    logic                          is_border;
    logic                          last_of_matrix;

    modport source (output valid, mean_value, no_valid_neighbour, is_border,
                    last_of_matrix, input ready);
    modport sink   (input valid, mean_value, no_valid_neighbour, is_border,
                    last_of_matrix, output ready);
endinterface

interface nmf_cfg_if;
    import nmf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/nmf_front.sv]
// ----------------------------------------------------------------------------
// nmf_front
// Sample intake: position tracking, border classification, column store and
// neighbour sum. Pushes one job per sample that releases results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmf_front #(
    parameter int MAX_ROWS = nmf_pkg::DEFAULT_MAX_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nmf_cfg_if.sink       i_cfg,
    nmf_sample_if.sink    i_smp,
    input  logic          i_q_full,
    output logic          o_push,
    output nmf_pkg::t_job o_push_data
);
    import nmf_pkg::*;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int RST_ROWS = (RESET_ROW_COUNT > MAX_ROWS) ? MAX_ROWS : RESET_ROW_COUNT;

    logic [ROW_W-1:0]    r_rows_m1, n_rows_m1;
    logic [COL_BITS-1:0] r_cols_m1, n_cols_m1;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_BITS-1:0] r_col, n_col;

    logic                r_f2_valid;
    t_class              r_f2_cls;
    t_cell               r_f2_cur;
    logic [ROW_W-1:0]    r_f2_row;
    t_line_entry         r_rd_a;
    t_line_entry         r_rd_b;
    t_cell               r_up;
    t_line_entry         r_store [MAX_ROWS];

    logic                cfg_wr;
    logic                cfg_hit;
    logic [31:0]         row_req;
    logic                acc;
    t_class              cls;
    logic                f2_need;
    logic                f2_done;
    t_cell               nb [4];
    logic [SUM_BITS-1:0] sum;
    logic [CNT_BITS-1:0] cnt;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign cfg_hit     = cfg_wr && (i_cfg.index == CFG_ROW_COUNT ||
                                    i_cfg.index == CFG_COLUMN_COUNT);
    assign row_req     = 32'(i_cfg.data[ROW_CFG_BITS-1:0]);

    always_comb begin
        n_rows_m1 = r_rows_m1;
        n_cols_m1 = r_cols_m1;
        if (cfg_wr) begin
            case (i_cfg.index)
                CFG_ROW_COUNT: begin
                    if (row_req == 32'd0) begin
                        n_rows_m1 = '0;
                    end else if (row_req > 32'(MAX_ROWS)) begin
                        n_rows_m1 = ROW_W'(MAX_ROWS - 1);
                    end else begin
                        n_rows_m1 = ROW_W'(row_req - 32'd1);
                    end
                end
                CFG_COLUMN_COUNT: begin
                    if (i_cfg.data[COL_BITS-1:0] == '0) begin
                        n_cols_m1 = '0;
                    end else begin
                        n_cols_m1 = i_cfg.data[COL_BITS-1:0] - COL_BITS'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // F2 holds the sample while its row is read; it retires once its job, if any, is queued
    assign f2_need     = r_f2_valid && (r_f2_cls.has_first || r_f2_cls.has_second);
    assign f2_done     = r_f2_valid && !(f2_need && i_q_full);
    assign i_smp.ready = !r_f2_valid || f2_done;
    assign acc         = i_smp.valid && i_smp.ready;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (cfg_hit) begin
            n_row = '0;
            n_col = '0;
        end else if (acc) begin
            if (r_row == r_rows_m1) begin
                n_row = '0;
                n_col = (r_col == r_cols_m1) ? '0 : r_col + COL_BITS'(1);
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    always_comb begin
        cls.has_first    = r_col != '0;
        cls.first_border = r_row == '0 || r_row == r_rows_m1 || r_col == COL_BITS'(1);
        cls.has_second   = r_col == r_cols_m1;
        cls.last         = r_row == r_rows_m1;
    end

    // up, right, down, left of the centre (row, column - 1)
    assign nb[0] = r_up;
    assign nb[1] = r_f2_cur;
    assign nb[2] = r_rd_b.prev;
    assign nb[3] = r_rd_a.old;

    always_comb begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < 4; i++) begin
            if (!nb[i].missing) begin
                sum = sum + {{(SUM_BITS - SAMPLE_BITS){nb[i].value[SAMPLE_BITS-1]}},
                             nb[i].value};
                cnt = cnt + CNT_BITS'(1);
            end
        end
    end

    assign o_push           = f2_need && !i_q_full;
    assign o_push_data.sum  = sum;
    assign o_push_data.cnt  = cnt;
    assign o_push_data.cls  = r_f2_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1  <= ROW_W'(RST_ROWS - 1);
            r_cols_m1  <= COL_BITS'(RESET_COLUMN_COUNT - 1);
            r_row      <= '0;
            r_col      <= '0;
            r_f2_valid <= 1'b0;
        end else begin
            r_rows_m1 <= n_rows_m1;
            r_cols_m1 <= n_cols_m1;
            r_row     <= n_row;
            r_col     <= n_col;
            if (acc) begin
                r_f2_valid <= 1'b1;
            end else if (f2_done) begin
                r_f2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_f2_cls <= cls;
            r_f2_cur <= '{value: i_smp.sample_value, missing: i_smp.sample_missing};
            r_f2_row <= r_row;
            r_rd_a   <= r_store[r_row];
            r_rd_b   <= r_store[r_row + ROW_W'(1)];
        end
        if (f2_done) begin
            r_store[r_f2_row] <= '{prev: r_f2_cur, old: r_rd_a.prev};
            r_up              <= r_rd_a.prev;
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_rows_m1 && r_col <= r_cols_m1)
        else $error("sample position outside the configured matrix");

endmodule

[rtl/core/nmf_queue.sv]
// ----------------------------------------------------------------------------
// nmf_queue
// Short job FIFO between intake and arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nmf_pkg::t_job i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output nmf_pkg::t_job o_pop_data,
    output logic          o_empty
);
    import nmf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full     = r_count == (PTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty    = r_count == '0;
    assign o_pop_data = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (PTR_W + 1)'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job popped from empty queue");

endmodule

[rtl/core/nmf_back.sv]
// ----------------------------------------------------------------------------
// nmf_back
// Rounded division of the neighbour sum by the count, and the result
// register that expands a job into one or two result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  nmf_pkg::t_job i_q_data,
    output logic          o_pop,
    nmf_result_if.source  o_res
);
    import nmf_pkg::*;

    logic                   en;
    logic                   second_xfer;
    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS:0]      half_ext;
    logic [SUM_BITS:0]      x_wide;
    logic [PROD_BITS-1:0]   prod;
    logic [MAG_BITS-1:0]    q;
    logic [SAMPLE_BITS-1:0] mean;

    logic                   r_b1_valid;
    logic [MAG_BITS-1:0]    r_b1_x;
    logic                   r_b1_neg;
    logic [CNT_BITS-1:0]    r_b1_cnt;
    t_class                 r_b1_cls;

    logic                   r_b2_valid;
    logic [MAG_BITS-1:0]    r_b2_x;
    logic [PROD_BITS-1:0]   r_b2_prod;
    logic                   r_b2_neg;
    logic [CNT_BITS-1:0]    r_b2_cnt;
    t_class                 r_b2_cls;

    logic                   r_out_valid;
    logic                   r_out_second;
    logic                   r_out_last2;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic                   r_out_none;
    logic                   r_out_border;
    logic                   r_out_last;

    assign second_xfer = r_out_valid && o_res.ready && r_out_second;
    assign en          = !r_out_valid || (o_res.ready && !r_out_second);
    assign o_pop       = en && !i_q_empty;

    // |sum| + count/2, sign kept apart
    assign sum_ext  = {i_q_data.sum[SUM_BITS-1], i_q_data.sum};
    assign half_ext = (SUM_BITS + 1)'(i_q_data.cnt[CNT_BITS-1:1]);
    assign x_wide   = i_q_data.sum[SUM_BITS-1] ? half_ext - sum_ext : sum_ext + half_ext;

    assign prod = PROD_BITS'(r_b1_x) * PROD_BITS'(DIV3_RECIP);

    always_comb begin
        case (r_b2_cnt)
            3'd1:    q = r_b2_x;
            3'd2:    q = r_b2_x >> 1;
            3'd3:    q = MAG_BITS'(r_b2_prod >> DIV3_SHIFT);
            3'd4:    q = r_b2_x >> 2;
            default: q = '0;
        endcase
    end

    assign mean = r_b2_neg ? SAMPLE_BITS'(0) - q[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid   <= 1'b0;
            r_b2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_second <= 1'b0;
        end else begin
            if (en) begin
                r_b1_valid <= o_pop;
                r_b2_valid <= r_b1_valid;
            end
            if (second_xfer) begin
                r_out_second <= 1'b0;
            end else if (en) begin
                r_out_valid  <= r_b2_valid;
                r_out_second <= r_b2_valid && r_b2_cls.has_first && r_b2_cls.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_x   <= x_wide[MAG_BITS-1:0];
            r_b1_neg <= i_q_data.sum[SUM_BITS-1];
            r_b1_cnt <= i_q_data.cnt;
            r_b1_cls <= i_q_data.cls;
        end
        if (en) begin
            r_b2_x    <= r_b1_x;
            r_b2_prod <= prod;
            r_b2_neg  <= r_b1_neg;
            r_b2_cnt  <= r_b1_cnt;
            r_b2_cls  <= r_b1_cls;
        end
        if (second_xfer) begin
            r_out_mean   <= '0;
            r_out_none   <= 1'b0;
            r_out_border <= 1'b1;
            r_out_last   <= r_out_last2;
        end else if (en && r_b2_valid) begin
            r_out_last2 <= r_b2_cls.last;
            if (r_b2_cls.has_first) begin
                r_out_mean   <= r_b2_cls.first_border ? '0 : mean;
                r_out_none   <= !r_b2_cls.first_border && r_b2_cnt == '0;
                r_out_border <= r_b2_cls.first_border;
                r_out_last   <= 1'b0;
            end else begin
                r_out_mean   <= '0;
                r_out_none   <= 1'b0;
                r_out_border <= 1'b1;
                r_out_last   <= r_b2_cls.last;
            end
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.mean_value         = r_out_mean;
    assign o_res.no_valid_neighbour = r_out_none;
    assign o_res.is_border          = r_out_border;
    assign o_res.last_of_matrix     = r_out_last;

    a_second_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_second |-> r_out_valid)
        else $error("second result pending without a valid result");

    a_second_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        second_xfer |=> (r_out_valid && r_out_border && r_out_mean == '0 && !r_out_none))
        else $error("last-column result is not a border zero");

endmodule

[rtl/core/four_neighbour_mean_filter.sv]
// ----------------------------------------------------------------------------
// four_neighbour_mean_filter
// Samples of a row_count x column_count matrix enter in column-major order,
// each with a missing flag. Every sample releases the result of the element
// one column back in the same row (none in column 0); a sample of the last
// column also releases its own border result, so those past column 0 give two
// result transactions. Interior results are the mean of the present up, down,
// left and right neighbours, rounded to nearest with ties away from zero;
// with no neighbour present the mean is zero and no_valid_neighbour is set.
// The block takes one sample per clock while its job queue is not full; the
// column store reads two rows and writes one row per sample. A result goes
// from its releasing sample through the F2 register, the job queue and the
// B1, B2 and output registers. Writing either configuration register
// restarts the matrix at row 0, column 0; write only between transactions.
// The column store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_neighbour_mean_filter #(
    parameter int MAX_ROWS = nmf_pkg::DEFAULT_MAX_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nmf_cfg_if.sink       i_cfg,
    nmf_sample_if.sink    i_sample,
    nmf_result_if.source  o_result
);
    import nmf_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job push_data;
    t_job pop_data;

    nmf_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_smp       (i_sample),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    nmf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    nmf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (pop_data),
        .o_pop     (pop),
        .o_res     (o_result)
    );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for four_neighbour_mean_filter. A predictor follows
// every accepted sample, keeps its own column store and matrix position, and
// queues the result transactions each sample releases. A checker pops one
// entry per accepted result transaction and compares every field. Named tests
// cover the reset geometry, neighbour cases, degenerate sizes, ignored
// register writes, restarts, the largest sizes, backpressure and random
// matrices under several idle profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import nmf_pkg::*;

    localparam int CLK_PERIOD        = 4;
    localparam int RESET_CYCLES      = 12;
    localparam int SETTLE_CYCLES     = 20;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int TIMEOUT_NS        = 10_000_000;
    localparam int MAX_ROWS          = DEFAULT_MAX_ROWS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOP_INDEX   = 4'd15;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] FILLER     = 24'sh5A5A5A;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic                          none;
        logic                          border;
        logic                          last;
    } t_filter_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nmf_cfg_if    cfg_if ();
    nmf_sample_if smp_if ();
    nmf_result_if res_if ();

    four_neighbour_mean_filter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_sample (smp_if),
        .o_result (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    logic [ROW_CFG_BITS-1:0] model_rows;
    logic [COL_BITS-1:0]     model_cols;
    t_cell                   prev_col  [MAX_ROWS];
    t_cell                   older_col [MAX_ROWS];
    int                      row_pos;
    int                      col_pos;
    t_filter_result          pending_results [$];

    int fail_count     = 0;
    int send_idle_pct  = 32;
    int recv_idle_pct  = 82;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;

    task automatic predict_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic m);
        int             rows;
        int             cols;
        int             r;
        int             c;
        int             oc;
        int             cnt;
        int             i;
        longint         acc;
        longint         mag;
        longint         q;
        t_cell          nb [4];
        t_cell          centre;
        t_filter_result res;
        rows = (model_rows == 0) ? 1 : ((model_rows > MAX_ROWS) ? MAX_ROWS : int'(model_rows));
        cols = (model_cols == 0) ? 1 : int'(model_cols);
        r = (row_pos >= rows) ? 0 : row_pos;
        c = (col_pos >= cols) ? 0 : col_pos;
        centre.value   = v;
        centre.missing = m;
        if (c >= 1) begin
            oc  = c - 1;
            res = '{mean: '0, none: 1'b0, border: 1'b0, last: 1'b0};
            if (r == 0 || r == rows - 1 || oc == 0 || oc == cols - 1) begin
                res.border = 1'b1;
            end else begin
                // up neighbour was moved to the older column one sample ago
                nb[0] = older_col[r-1];
                nb[1] = centre;
                nb[2] = prev_col[r+1];
                nb[3] = older_col[r];
                acc = 0;
                cnt = 0;
                for (i = 0; i < 4; i++) begin
                    if (!nb[i].missing) begin
                        acc += longint'($signed(nb[i].value));
                        cnt++;
                    end
                end
                if (cnt == 0) begin
                    res.none = 1'b1;
                end else begin
                    mag = (acc < 0) ? -acc : acc;
                    q   = (mag + cnt / 2) / cnt;
                    res.mean = SAMPLE_BITS'((acc < 0) ? -q : q);
                end
            end
            pending_results.push_back(res);
        end
        older_col[r] = prev_col[r];
        prev_col[r]  = centre;
        if (c == cols - 1) begin
            res = '{mean: '0, none: 1'b0, border: 1'b1, last: (r == rows - 1)};
            pending_results.push_back(res);
        end
        r++;
        if (r >= rows) begin
            r = 0;
            c++;
            if (c >= cols) c = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic apply_register_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_ROW_COUNT) begin
            model_rows = data[ROW_CFG_BITS-1:0];
            row_pos    = 0;
            col_pos    = 0;
        end else if (idx == CFG_COLUMN_COUNT) begin
            model_cols = data[COL_BITS-1:0];
            row_pos    = 0;
            col_pos    = 0;
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic m);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.sample_value   <= v;
        smp_if.sample_missing <= m;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        predict_sample(v, m);
    endtask

    task automatic wait_for_drain();
        smp_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // column 0 samples release nothing, so let the pipeline empty
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high; caller lowers it after the last write
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_register_write(idx, data);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] rows_data,
                                input logic [CFG_DATA_BITS-1:0] cols_data);
        wait_for_drain();
        write_register(CFG_ROW_COUNT, rows_data);
        write_register(CFG_COLUMN_COUNT, cols_data);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'(int'($urandom_range(32)) - 16);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic stream_random_samples(input int count, input int miss_pct);
        int k;
        for (k = 0; k < count; k++) begin
            send_sample(random_sample(), $urandom_range(99) < miss_pct);
        end
    endtask

    task automatic test_reset_geometry();
        // 256 rows after reset: column 0 releases nothing
        stream_random_samples(16, 20);
    endtask

    task automatic test_neighbour_cases();
        logic signed [SAMPLE_BITS-1:0] vals [21];
        logic                          miss [21];
        int                            k;
        vals = '{SAMPLE_MAX, FILLER,     SAMPLE_MIN,
                 FILLER,     SAMPLE_MAX, FILLER,
                 SAMPLE_MAX, FILLER,     SAMPLE_MAX,
                 SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                 FILLER,     SAMPLE_MIN, FILLER,
                 FILLER,     SAMPLE_MIN, FILLER,
                 24'sd1,     FILLER,     -24'sd1};
        // col 1: no neighbour; col 2: missing centre, four at max;
        // col 3: three at min; col 4: tie at -1/2; col 5: single neighbour
        miss = '{1'b0, 1'b1, 1'b0,
                 1'b1, 1'b0, 1'b1,
                 1'b0, 1'b1, 1'b0,
                 1'b0, 1'b0, 1'b0,
                 1'b1, 1'b0, 1'b1,
                 1'b1, 1'b0, 1'b1,
                 1'b0, 1'b1, 1'b0};
        set_geometry(16'd3, 16'd7);
        for (k = 0; k < 21; k++) begin
            send_sample(vals[k], miss[k]);
        end
    endtask

    task automatic test_small_geometries();
        set_geometry(16'h0000, 16'h0000);
        stream_random_samples(5, 20);
        set_geometry(16'hF801, 16'd2);
        stream_random_samples(6, 20);
        set_geometry(16'd2, 16'd3);
        stream_random_samples(12, 20);
        set_geometry(16'd3, 16'd1);
        stream_random_samples(7, 20);
        set_geometry(16'd3, 16'd2);
        stream_random_samples(8, 20);
    endtask

    task automatic test_ignored_register_index();
        set_geometry(16'd4, 16'd5);
        stream_random_samples(7, 20);
        wait_for_drain();
        write_register(CFG_SPARE_INDEX, 16'h0003);
        write_register(CFG_TOP_INDEX, 16'hFFFF);
        cfg_if.valid <= 1'b0;
        stream_random_samples(13, 20);
    endtask

    task automatic test_restart_mid_matrix();
        set_geometry(16'd5, 16'd6);
        stream_random_samples(13, 20);
        wait_for_drain();
        write_register(CFG_COLUMN_COUNT, 16'd6);
        cfg_if.valid <= 1'b0;
        stream_random_samples(30, 20);
        stream_random_samples(7, 20);
        wait_for_drain();
        write_register(CFG_ROW_COUNT, 16'd5);
        cfg_if.valid <= 1'b0;
        stream_random_samples(30, 20);
    endtask

    task automatic test_tallest_columns();
        // 2047 saturates to the store depth
        set_geometry(16'hFFFF, 16'd3);
        stream_random_samples(MAX_ROWS + 4, 15);
    endtask

    task automatic test_widest_matrix();
        set_geometry(16'd3, 16'hFFFF);
        stream_random_samples(12, 15);
    endtask

    task automatic test_output_backpressure();
        set_geometry(16'd6, 16'd8);
        stall_requests++;
        stream_random_samples(50, 10);
        wait_for_drain();
        stream_random_samples(20, 10);
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int goal);
        int sent;
        int rows_data;
        int cols_data;
        int rows_eff;
        int cols_eff;
        int n;
        int miss;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < goal) begin
            if ($urandom_range(9) == 0) begin
                rows_data = $urandom_range(2);
                cols_data = $urandom_range(3);
            end else begin
                rows_data = $urandom_range(3, 6);
                cols_data = $urandom_range(3, 6);
            end
            case ($urandom_range(3))
                0: miss = 0;
                1: miss = 15;
                2: miss = 50;
                default: miss = 95;
            endcase
            rows_eff = (rows_data == 0) ? 1 : rows_data;
            cols_eff = (cols_data == 0) ? 1 : cols_data;
            n = rows_eff * cols_eff * $urandom_range(1, 2);
            if ($urandom_range(5) == 0) n = $urandom_range(1, n);
            set_geometry(CFG_DATA_BITS'(rows_data), CFG_DATA_BITS'(cols_data));
            stream_random_samples(n, miss);
            sent += n;
        end
    endtask

    task automatic test_random_matrices();
        run_random_phase(32, 82, 30);
        run_random_phase(82, 32, 30);
        run_random_phase(0, 0, 30);
    endtask

    // long receiver hold-off, one per request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_requests) begin
            stall_left   <= LONG_STALL_CYCLES;
            stall_served <= stall_requests;
        end
    end

    always @(posedge i_clk) begin
        t_filter_result want;
        res_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.mean_value !== want.mean) begin
                    $error("mean_value: expected %0d, got %0d", want.mean, res_if.mean_value);
                    fail_count++;
                end
                if (res_if.no_valid_neighbour !== want.none) begin
                    $error("no_valid_neighbour: expected %0b, got %0b",
                           want.none, res_if.no_valid_neighbour);
                    fail_count++;
                end
                if (res_if.is_border !== want.border) begin
                    $error("is_border: expected %0b, got %0b", want.border, res_if.is_border);
                    fail_count++;
                end
                if (res_if.last_of_matrix !== want.last) begin
                    $error("last_of_matrix: expected %0b, got %0b",
                           want.last, res_if.last_of_matrix);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        smp_if.valid          = 1'b0;
        smp_if.sample_value   = '0;
        smp_if.sample_missing = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        model_rows            = ROW_CFG_BITS'(RESET_ROW_COUNT);
        model_cols            = COL_BITS'(RESET_COLUMN_COUNT);
        row_pos               = 0;
        col_pos               = 0;
        foreach (prev_col[i]) begin
            prev_col[i]  = '0;
            older_col[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_neighbour_cases();
        test_small_geometries();
        test_ignored_register_index();
        test_restart_mid_matrix();
        test_tallest_columns();
        test_widest_matrix();
        test_output_backpressure();
        test_random_matrices();

        wait_for_drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/nmf_pkg.sv
rtl/core/nmf_if.sv
rtl/core/nmf_front.sv
rtl/core/nmf_queue.sv
rtl/core/nmf_back.sv
rtl/core/four_neighbour_mean_filter.sv
tb/sv/tb_top.sv
